[rtl/mfpc_pkg.sv]
// shared types and constants for the minimum falling path cost block
`timescale 1ns / 1ps
package mfpc_pkg;

  // configuration port geometry
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  // register indexes, decoded from paddr[2]
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  localparam int unsigned ROWS_W = 16;
  localparam int unsigned COLS_W = 7;
  localparam int unsigned CELL_W = 16;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [ROWS_W-1:0] rows;
    logic [COLS_W-1:0] cols;
    logic              restart;
  } cfg_t;

endpackage

[rtl/min_falling_path_cost_top.sv]
// minimum falling path cost over a streamed grid, top level
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  input   | in        | in_valid / in_stall  | cell_cost[15:0]
//  output  | out       | out_valid/ out_stall | min_cost[31:0], saturated
//  config  | in        | apb psel/penable     | paddr[2:0], pwdata[31:0]
//
// one cell per cycle while in_stall is low; an accepted final cell reaches the
// output register through memory read, then add and compare and write back
// rate is set by the row memory: one read of columns j and j+1 and one
// write of column j per cell, with forwarding from the write-back stage
// rst is synchronous and active high; it clears positions and the running minimum
// a stalled output holds the final cell in the write-back stage and stalls input
`timescale 1ns / 1ps
module min_falling_path_cost_top
  import mfpc_pkg::*;
#(
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned COST_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // cell input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CELL_W-1:0]     cell_cost,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           min_cost,
  output logic                  saturated,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned EXT_W = (COST_BITS > CELL_W) ? COST_BITS : CELL_W;
  localparam int unsigned SW    = EXT_W + 1;
  localparam int unsigned MW    = (COST_BITS > 32) ? COST_BITS : 32;
  localparam logic [COST_BITS-1:0] COST_MAX = '1;

  cfg_t cfg;

  mfpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // effective grid shape: zero acts as one, columns clip at MAX_COLS
  logic [CW-1:0]     cols_last;
  logic [ROWS_W-1:0] rows_last;

  always_comb begin
    if (cfg.cols == '0) begin
      cols_last = '0;
    end else if (32'(cfg.cols) > MAX_COLS) begin
      cols_last = CW'(MAX_COLS - 1);
    end else begin
      cols_last = CW'(cfg.cols - COLS_W'(1));
    end
    rows_last = (cfg.rows == '0) ? '0 : cfg.rows - ROWS_W'(1);
  end

  // ---------------------------------------------------------------
  // accept stage: grid position counters and memory read issue
  // ---------------------------------------------------------------
  logic [CW-1:0]     col_pos;
  logic [ROWS_W-1:0] row_pos;
  logic              in_accept;
  logic              col_end;
  logic              row_end;
  logic [CW-1:0]     next_addr;

  assign in_accept = in_valid && !in_stall;
  assign col_end   = (col_pos == cols_last);
  assign row_end   = (row_pos == rows_last);
  assign next_addr = col_pos + CW'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (in_accept) begin
      if (col_end) begin
        col_pos <= '0;
        row_pos <= row_end ? '0 : row_pos + ROWS_W'(1);
      end else begin
        col_pos <= next_addr;
      end
    end
  end

  // ---------------------------------------------------------------
  // write-back stage registers
  // ---------------------------------------------------------------
  logic                 b_valid;
  logic [CELL_W-1:0]    b_cost;
  logic [CW-1:0]        b_col;
  logic                 b_first_row;
  logic                 b_last_row;
  logic                 b_has_left;
  logic                 b_has_next;
  logic                 b_final;
  logic                 fwd_here;
  logic                 fwd_next;
  logic [COST_BITS-1:0] fwd_val;
  logic [COST_BITS-1:0] left_prev;
  logic [COST_BITS-1:0] running_min;
  logic                 sat_seen;

  logic [COST_BITS-1:0] rd_here;
  logic [COST_BITS-1:0] rd_next;
  logic [COST_BITS-1:0] here_val;
  logic [COST_BITS-1:0] next_val;
  logic [COST_BITS-1:0] best;
  logic [SW-1:0]        sum_ext;
  logic                 sat_now;
  logic [COST_BITS-1:0] fresh;
  logic [COST_BITS-1:0] min_sel;
  logic [MW-1:0]        min_ext;
  logic                 out_free;
  logic                 b_adv;

  mfpc_row_mem #(
    .DEPTH (MAX_COLS),
    .WIDTH (COST_BITS),
    .AW    (CW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (b_adv),
    .wr_addr   (b_col),
    .wr_data   (fresh),
    .rd_en     (in_accept),
    .rd_addr_a (col_pos),
    .rd_addr_b (next_addr),
    .rd_data_a (rd_here),
    .rd_data_b (rd_next)
  );

  // previous-row values, with the same-edge write forwarded
  assign here_val = fwd_here ? fwd_val : rd_here;
  assign next_val = fwd_next ? fwd_val : rd_next;

  always_comb begin
    best = here_val;
    if (b_has_left && left_prev < best) begin
      best = left_prev;
    end
    if (b_has_next && next_val < best) begin
      best = next_val;
    end
    if (b_first_row) begin
      best = '0;
    end
  end

  // saturating add at the cost maximum
  assign sum_ext = SW'(best) + SW'(b_cost);
  assign sat_now = sum_ext > SW'(COST_MAX);
  assign fresh   = sat_now ? COST_MAX : sum_ext[COST_BITS-1:0];

  assign min_sel = (b_last_row && fresh < running_min) ? fresh : running_min;
  assign min_ext = MW'(min_sel);

  // a final cell waits here until the output register frees up
  assign out_free = !out_valid || !out_stall;
  assign b_adv    = b_valid && (!b_final || out_free);
  assign in_stall = b_valid && !b_adv;

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      b_valid <= 1'b0;
    end else if (in_accept) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  // payload of the write-back stage
  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_cost      <= cell_cost;
      b_col       <= col_pos;
      b_first_row <= (row_pos == '0);
      b_last_row  <= row_end;
      b_has_left  <= (col_pos != '0);
      b_has_next  <= !col_end;
      b_final     <= col_end && row_end;
      fwd_here    <= b_adv && (b_col == col_pos);
      fwd_next    <= b_adv && (b_col == next_addr);
      fwd_val     <= fresh;
    end
  end

  // left neighbor of the previous row, saved before it is overwritten
  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      left_prev <= '0;
    end else if (b_adv) begin
      left_prev <= here_val;
    end
  end

  // running minimum over the last row and the saturation mark
  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      running_min <= COST_MAX;
      sat_seen    <= 1'b0;
    end else if (b_adv) begin
      if (b_final) begin
        running_min <= COST_MAX;
        sat_seen    <= 1'b0;
      end else begin
        running_min <= min_sel;
        sat_seen    <= sat_seen || sat_now;
      end
    end
  end

  // output register: one transaction per grid
  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      out_valid <= 1'b0;
    end else if (b_adv && b_final) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_final) begin
      min_cost  <= min_ext[31:0];
      saturated <= sat_seen || sat_now;
    end
  end

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col_pos <= cols_last)
    else $error("column position beyond configured columns");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row_pos <= rows_last)
    else $error("row position beyond configured rows");

  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_valid && b_final))
    else $error("result raised without a final cell");

  a_final_held: assert property (@(posedge clk) disable iff (rst || cfg.restart)
    b_valid && b_final && !out_free |=> b_valid && b_final)
    else $error("final cell dropped while output was full");
`endif

endmodule

[rtl/mfpc_cfg_regs.sv]
// apb register file for grid rows and columns
`timescale 1ns / 1ps
module mfpc_cfg_regs
  import mfpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [ROWS_W-1:0] grid_rows;
  logic [COLS_W-1:0] grid_cols;
  logic              restart;
  logic              wr_en;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= ROWS_W'(1);
      grid_cols <= COLS_W'(1);
      restart   <= 1'b0;
    end else begin
      restart <= wr_en;
      if (wr_en) begin
        unique case (reg_sel)
          REG_GRID_ROWS: grid_rows <= pwdata[ROWS_W-1:0];
          REG_GRID_COLS: grid_cols <= pwdata[COLS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GRID_ROWS: prdata = CFG_DATA_W'(grid_rows);
      REG_GRID_COLS: prdata = CFG_DATA_W'(grid_cols);
      default:       prdata = '0;
    endcase
  end

  // restart is combinational so the datapath clears in the write cycle itself
  assign cfg.rows    = grid_rows;
  assign cfg.cols    = grid_cols;
  assign cfg.restart = wr_en;

  // restart registered copy is only tracked for the assertion below
`ifndef SYNTHESIS
  a_restart_follows_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> restart)
    else $error("restart flag did not follow a register write");
`endif

endmodule

[rtl/mfpc_row_mem.sv]
// row cost memory: one write port, two registered read ports
`timescale 1ns / 1ps
module mfpc_row_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read before write on the same edge; the caller forwards
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
